/* src/sgr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_pkg: shared definitions for the stream group reverser
// Sizes, controller states and the control word that drives the cell chain.
// ----------------------------------------------------------------------------
package sgr_pkg;

    localparam int MAX_GROUP = 16;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 5;
    localparam int CNT_W     = $clog2(MAX_GROUP + 1);
    localparam int IDX_W     = $clog2(MAX_GROUP);
    localparam int CMP_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_EMIT
    } sgr_state_t;

    // Control word broadcast to every cell of the chain
    typedef struct packed {
        logic shift_up;    // push: take the value of the lower neighbour
        logic shift_down;  // pop newest: take the value of the upper neighbour
    } sgr_cell_ctrl_t;

endpackage

/* src/sgr_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_cell: one storage cell of the group chain
// Holds one pending value and moves it to a neighbour on push or pop.
// ----------------------------------------------------------------------------
module sgr_cell (
    input  logic                          clk,
    input  sgr_pkg::sgr_cell_ctrl_t       ctrl,
    input  logic signed [sgr_pkg::DATA_W-1:0] up_data,
    input  logic signed [sgr_pkg::DATA_W-1:0] down_data,
    output logic signed [sgr_pkg::DATA_W-1:0] q
);
    import sgr_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    // Select the neighbour to take from, else hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_up)
        begin
            data_next = up_data;
        end
        else if (ctrl.shift_down)
        begin
            data_next = down_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

/* src/stream_group_reverser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_group_reverser: reverses a value stream in groups of group_size
// Chain of cells holding the pending group, a small controller and an
// output register.
// ----------------------------------------------------------------------------
// While a group is being collected one transaction is taken per clock. The
// transaction that completes a group (or carries end_of_list) is followed
// by input stall while its results unload from the cell chain, one per
// clock while the output is not stalled; the unload is paced by the single
// output register. A completed group is sent newest first; a short group
// closed by end_of_list is sent oldest first. group_size 0 acts as 1 and
// values above 16 act as 16; it is to be written only while the block is
// idle. The last result of a transaction carries run_last, and list_last
// marks the last result of an end_of_list transaction.
// ----------------------------------------------------------------------------
module stream_group_reverser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sgr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sgr_pkg::DATA_W-1:0] value,
    input  logic                              end_of_list,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sgr_pkg::DATA_W-1:0] value_out,
    output logic                              run_last,
    output logic                              list_last
);
    import sgr_pkg::*;

    sgr_state_t             state_reg, state_next;
    logic [CFG_W-1:0]       group_size_reg, group_size_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   reverse_reg, reverse_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg, out_value_next;
    logic                   out_run_reg, out_run_next;
    logic                   out_list_reg, out_list_next;

    logic                   in_fire;
    logic                   pop;
    logic                   group_full;
    logic [CNT_W-1:0]       fill_plus;
    logic [CNT_W-1:0]       count_minus;
    logic [CMP_W-1:0]       fill_cmp;
    logic [CMP_W-1:0]       size_cmp;
    sgr_cell_ctrl_t         cell_ctrl;
    logic signed [DATA_W-1:0] cell_q [MAX_GROUP];
    logic signed [DATA_W-1:0] oldest_value;

    // Handshake and group-size compare
    assign in_fire     = in_valid && !in_stall;
    assign pop         = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign fill_plus   = count_reg + CNT_W'(1);
    assign count_minus = count_reg - CNT_W'(1);
    assign fill_cmp    = CMP_W'(fill_plus);
    assign size_cmp    = CMP_W'(group_size_reg);
    assign group_full  = (group_size_reg == '0) || (fill_cmp >= size_cmp) ||
                         (fill_cmp >= CMP_W'(MAX_GROUP));

    // Cell chain: cell 0 holds the newest value
    assign cell_ctrl.shift_up   = in_fire;
    assign cell_ctrl.shift_down = pop && reverse_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_GROUP; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] up_data;
            logic signed [DATA_W-1:0] down_data;
            if (gi == 0)
            begin : g_first
                assign up_data = value;
            end
            else
            begin : g_mid
                assign up_data = cell_q[gi-1];
            end
            if (gi == MAX_GROUP - 1)
            begin : g_top
                assign down_data = '0;
            end
            else
            begin : g_inner
                assign down_data = cell_q[gi+1];
            end
            sgr_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .up_data   (up_data),
                .down_data (down_data),
                .q         (cell_q[gi])
            );
        end
    endgenerate

    // Oldest pending value sits at the top of the filled part
    assign oldest_value = cell_q[count_minus[IDX_W-1:0]];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_fire && (group_full || end_of_list))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (pop && (count_reg == CNT_W'(1)))
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // Datapath and output register updates
    always_comb
    begin
        group_size_next = cfg_we ? cfg_data : group_size_reg;
        count_next      = count_reg;
        reverse_next    = reverse_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_run_next    = out_run_reg;
        out_list_next   = out_list_reg;
        in_stall        = 1'b1;
        case (state_reg)
            ST_COLLECT:
            begin
                in_stall = 1'b0;
                if (in_fire)
                begin
                    count_next   = fill_plus;
                    reverse_next = group_full;
                    last_next    = end_of_list;
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    count_next     = count_minus;
                    out_valid_next = 1'b1;
                    out_value_next = reverse_reg ? cell_q[0] : oldest_value;
                    out_run_next   = (count_reg == CNT_W'(1));
                    out_list_next  = (count_reg == CNT_W'(1)) && last_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_COLLECT;
            group_size_reg <= CFG_W'(2);
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            group_size_reg <= group_size_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        reverse_reg   <= reverse_next;
        last_reg      <= last_next;
        out_value_reg <= out_value_next;
        out_run_reg   <= out_run_next;
        out_list_reg  <= out_list_next;
    end

    assign out_valid = out_valid_reg;
    assign value_out = out_value_reg;
    assign run_last  = out_run_reg;
    assign list_last = out_list_reg;

endmodule

/* src/sgr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgr_checker: port-level checks for the stream group reverser
// Watches the top-level ports and is attached by the bind below.
// ----------------------------------------------------------------------------
module sgr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              end_of_list,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [sgr_pkg::DATA_W-1:0] value_out,
    input logic                              run_last,
    input logic                              list_last
);
    import sgr_pkg::*;

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_out))
        else $error("stalled result changed");

    // End of list always closes a run
    a_list_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && list_last |-> run_last)
        else $error("list_last without run_last");

    // An end-of-list transaction always starts an unload
    a_eol_unload: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && end_of_list |=> in_stall)
        else $error("end of list did not start an unload");

    // Results of one run follow without gaps
    a_run_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_last |=> out_valid)
        else $error("gap inside a run");

endmodule

bind stream_group_reverser sgr_checker u_sgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .end_of_list (end_of_list),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value_out   (value_out),
    .run_last    (run_last),
    .list_last   (list_last)
);

/* dv/stream_group_reverser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_group_reverser_test: self-checking bench for the group reverser
// A clocked driver sends values from a queue of pending items, and a clocked
// monitor checks every result against a local model of the group buffer.
// A short directed part covers the extreme values and the special group
// sizes. Random lists follow under several group sizes and idle patterns.
// ----------------------------------------------------------------------------
module stream_group_reverser_test;

    import sgr_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 38;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     end_of_list;
    } stream_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     run_last;
        logic                     list_last;
    } group_result_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_we      = 1'b0;
    logic [CFG_W-1:0]         cfg_data    = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic signed [DATA_W-1:0] in_value    = '0;
    logic                     in_end      = 1'b0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic signed [DATA_W-1:0] value_out;
    logic                     run_last;
    logic                     list_last;

    stream_item_t  pending_values[$];
    group_result_t awaited_results[$];
    stream_item_t  next_item;
    group_result_t seen_result;

    // Local copy of the block state
    logic [DATA_W-1:0] group_store [MAX_GROUP];
    int unsigned       fill_level  = 0;
    logic [CFG_W-1:0]  size_reg    = 5'd2;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned idle_cycles   = 0;
    int unsigned fail_count    = 0;

    stream_group_reverser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .value      (in_value),
        .end_of_list(in_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_out  (value_out),
        .run_last   (run_last),
        .list_last  (list_last)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int unsigned active_size();
        if (size_reg == '0)
            return 1;
        if (size_reg > MAX_GROUP)
            return MAX_GROUP;
        return 32'(size_reg);
    endfunction

    // Store one value and queue the results that it releases
    function automatic void reverse_group(input logic [DATA_W-1:0] v, input logic eol);
        int unsigned   k;
        int unsigned   n;
        int unsigned   i;
        group_result_t r;
        k = active_size();
        if (fill_level >= MAX_GROUP)
            fill_level = 0;
        group_store[fill_level] = v;
        fill_level++;
        n = fill_level;
        if (n >= k || eol)
        begin
            for (i = 0; i < n; i++)
            begin
                r.value     = (n >= k) ? group_store[n - 1 - i] : group_store[i];
                r.run_last  = (i == n - 1);
                r.list_last = eol && (i == n - 1);
                awaited_results.insert(awaited_results.size(), r);
            end
            fill_level = 0;
        end
    endfunction

    // Driver: record the accepted transaction, then offer the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                reverse_group(in_value, in_end);
            if (!in_valid || !in_stall)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_item = pending_values.pop_front();
                    in_valid <= 1'b1;
                    in_value <= next_item.value;
                    in_end   <= next_item.end_of_list;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result value_out=%0d", value_out);
                    fail_count++;
                end
                else
                begin
                    seen_result = awaited_results.pop_front();
                    if (value_out !== seen_result.value)
                    begin
                        $error("value_out: expected %0d, got %0d", seen_result.value, value_out);
                        fail_count++;
                    end
                    if (run_last !== seen_result.run_last)
                    begin
                        $error("run_last: expected %0b, got %0b", seen_result.run_last, run_last);
                        fail_count++;
                    end
                    if (list_last !== seen_result.list_last)
                    begin
                        $error("list_last: expected %0b, got %0b",
                               seen_result.list_last, list_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Count cycles in which no transaction moves
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    task automatic push_value(input logic [DATA_W-1:0] v, input logic eol);
        stream_item_t it;
        it.value       = v;
        it.end_of_list = eol;
        pending_values.insert(pending_values.size(), it);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Hold the sender until every result is back and the block has settled
    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (pending_values.size() != 0 || in_valid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_group_size(input logic [CFG_W-1:0] size);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= size;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_reg = size;
    endtask

    // Queue random lists, mostly closed by end_of_list
    task automatic queue_random_lists(input int unsigned target);
        int unsigned count;
        int unsigned len;
        int unsigned k;
        int unsigned i;
        logic        closed;
        count = 0;
        k     = active_size();
        while (count < target)
        begin
            case ($urandom_range(3))
                0:       len = (k > 1) ? $urandom_range(k - 1, 1) : 1;
                1:       len = k * $urandom_range(3, 1);
                default: len = $urandom_range(40, 1);
            endcase
            // Trim the last list so the phase sends exactly its share
            if (count + len > target)
                len = target - count;
            closed = (count + len >= target) || ($urandom_range(7) != 0);
            for (i = 0; i < len; i++)
                push_value(pick_value(), closed && (i == len - 1));
            count += len;
        end
    endtask

    task automatic run_random_phase(input logic [CFG_W-1:0] size);
        wait_until_drained();
        write_group_size(size);
        queue_random_lists(PHASE_ITEMS);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 21;
        recv_idle_pct = 54;

        // Reset size of two: extremes reversed, then a single short group
        push_value(32'h8000_0000, 1'b0);
        push_value(32'h7FFF_FFFF, 1'b0);
        push_value(32'h0000_0000, 1'b1);

        // Size one passes values straight through
        wait_until_drained();
        write_group_size(5'd1);
        push_value(32'hFFFF_FFFF, 1'b0);
        push_value(32'h5555_5555, 1'b1);

        // Size zero acts as one
        wait_until_drained();
        write_group_size(5'd0);
        push_value(32'hAAAA_AAAA, 1'b0);
        push_value(32'h0000_0001, 1'b1);

        // Full group closed by end_of_list
        wait_until_drained();
        write_group_size(5'd4);
        push_value(32'h0000_0010, 1'b0);
        push_value(32'h0000_0020, 1'b0);
        push_value(32'h0000_0030, 1'b0);
        push_value(32'h0000_0040, 1'b1);

        // Lower the size mid-group: the pending values leave reversed
        wait_until_drained();
        push_value(32'h1111_1111, 1'b0);
        push_value(32'h2222_2222, 1'b0);
        push_value(32'h3333_3333, 1'b0);
        wait_until_drained();
        write_group_size(5'd2);
        push_value(32'h4444_4444, 1'b0);

        // Random part: saturation and the other extremes first
        run_random_phase(5'd16);
        run_random_phase(5'd1);
        run_random_phase(5'd0);
        run_random_phase(5'd31);

        send_idle_pct = 54;
        recv_idle_pct = 21;
        run_random_phase(5'd2);
        run_random_phase(5'd3);
        run_random_phase(5'd7);
        run_random_phase(CFG_W'($urandom_range(31)));

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(CFG_W'($urandom_range(31)));
        run_random_phase(CFG_W'($urandom_range(16, 1)));
        run_random_phase(CFG_W'($urandom_range(31)));
        run_random_phase(CFG_W'($urandom_range(16, 1)));

        wait_until_drained();
        if (awaited_results.size() != 0)
        begin
            $error("%0d results never arrived", awaited_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
